// ----- hw/rtl/mts_pkg.sv -----
// Package for the marker target steering block.
// Holds register indexes, instruction and mode codes and fixed field widths.
// No dependencies.
package mts_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int COORD_W    = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_RADIUS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOCK_SIZE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FAR_SIZE      = 3'd4;

  localparam logic [11:0] RST_FRAME_WIDTH   = 12'd640;
  localparam logic [11:0] RST_FRAME_HEIGHT  = 12'd480;
  localparam logic [15:0] RST_CENTER_RADIUS = 16'd1920;
  localparam logic [15:0] RST_LOCK_SIZE     = 16'd2400;
  localparam logic [15:0] RST_FAR_SIZE      = 16'd800;

  localparam logic [3:0] INS_ROTATE_SCAN  = 4'd0;
  localparam logic [3:0] INS_DONE         = 4'd1;
  localparam logic [3:0] INS_LOCKED       = 4'd2;
  localparam logic [3:0] INS_FORWARD      = 4'd3;
  localparam logic [3:0] INS_HINT_RIGHT   = 4'd4;
  localparam logic [3:0] INS_HINT_LEFT    = 4'd5;
  localparam logic [3:0] INS_FWD_TURN_R   = 4'd6;
  localparam logic [3:0] INS_FWD_TURN_L   = 4'd7;
  localparam logic [3:0] INS_TURN_RIGHT   = 4'd8;
  localparam logic [3:0] INS_TURN_LEFT    = 4'd9;
  localparam logic [3:0] INS_CAMERA_DOWN  = 4'd10;
  localparam logic [3:0] INS_CAMERA_UP    = 4'd11;

  localparam logic [1:0] MODE_SCANNING   = 2'd0;
  localparam logic [1:0] MODE_TRACKING   = 2'd1;
  localparam logic [1:0] MODE_LOCKED     = 2'd2;
  localparam logic [1:0] MODE_APPROACH   = 2'd3;

  localparam logic [11:0] AMT_FAR     = 12'd100;
  localparam logic [11:0] AMT_CENTRED = 12'd20;
  localparam logic [11:0] AMT_VERT    = 12'd15;

  // Reciprocal of 5 in Q0.18, exact for 14-bit dividends.
  localparam logic [15:0] RECIP5 = 16'd52429;

  localparam int ROOT_STEPS = 17;

  typedef enum logic [1:0] {
    JOB_OBS  = 2'd0,
    JOB_SCAN = 2'd1,
    JOB_TGT  = 2'd2
  } job_t;

endpackage

// ----- hw/rtl/marker_target_steering_core.sv -----
// Marker target steering core: per-marker centre/size store and target steering.
// Depends on mts_pkg.
//
// An observation transaction (operation 0) keeps the input busy for two passes of
// the shared 18x18 multiplier for the corner diagonal, then for the bit-pair square
// root unit, before the marker store is written. A decide transaction (operation 1)
// that keeps its held target reads it from the store, squares its offset and the
// radius, classifies it and waits for the output register to be free. One that has
// to re-pick walks every marker id: an id that is not a candidate is passed over, a
// candidate goes through a store read, two squares and a root. With no marker
// observed yet, a decide emits a rotate-scan instruction directly.
// The multiplier and the root unit are shared by all steps under one
// sequencer, and the input is ready only while that sequencer is idle. The
// result sits in an output register, so a new transaction can be taken while
// a decision waits to be consumed. Store entries of ids never observed are read
// during a re-pick scan but never used. Configuration writes are taken on any cycle.
module marker_target_steering_core
  import mts_pkg::*;
#(
  parameter int MARKER_IDS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  operation,
  input  logic [5:0]            marker_id,
  input  logic [COORD_W-1:0]    corner0_x,
  input  logic [COORD_W-1:0]    corner0_y,
  input  logic [COORD_W-1:0]    corner1_x,
  input  logic [COORD_W-1:0]    corner1_y,
  input  logic [COORD_W-1:0]    corner2_x,
  input  logic [COORD_W-1:0]    corner2_y,
  input  logic [COORD_W-1:0]    corner3_x,
  input  logic [COORD_W-1:0]    corner3_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [3:0]            instruction,
  output logic [11:0]           amount,
  output logic [1:0]            mode,
  output logic                  target_valid,
  output logic [5:0]            target_id,
  output logic [6:0]            found_count,
  output logic [6:0]            scanned_count
);

  localparam int ID_W = $clog2(MARKER_IDS);
  localparam logic [ID_W-1:0] IDX_LAST = ID_W'(MARKER_IDS - 1);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_SCAN  = 11'b00000000010,
    S_TRD   = 11'b00000000100,
    S_FETCH = 11'b00000001000,
    S_SQX   = 11'b00000010000,
    S_SQY   = 11'b00000100000,
    S_ROOT  = 11'b00001000000,
    S_RR    = 11'b00010000000,
    S_CLASS = 11'b00100000000,
    S_PICK  = 11'b01000000000,
    S_EMIT  = 11'b10000000000
  } state_t;

  // Configuration registers
  logic [11:0] frame_width, frame_height;
  logic [15:0] center_radius, lock_size, far_size;

  // Control state
  state_t          state;
  job_t            job;
  logic [MARKER_IDS-1:0] seen_bits, scanned_bits;
  logic [6:0]      found_cnt, scanned_cnt;
  logic [ID_W-1:0] target_reg;
  logic            target_held;
  logic [1:0]      mode_reg;
  logic [ID_W-1:0] idx;
  logic            best_found;
  logic [4:0]      root_cnt;

  // Datapath registers
  logic [5:0]        id_q;
  logic [15:0]       c_q [8];
  logic signed [17:0] dx_r, dy_r;
  logic [33:0]       acc;
  logic [31:0]       rr;
  logic [33:0]       rad;
  logic [17:0]       rem;
  logic [16:0]       root;
  logic signed [19:0] best_score;
  logic [ID_W-1:0]   best_id;
  logic [3:0]        res_ins;
  logic [11:0]       res_amt;

  // Marker store: centre x, centre y, size
  logic [47:0]     mem [MARKER_IDS];
  logic [47:0]     rdata;
  logic [ID_W-1:0] rd_addr;

  logic [15:0] m_cx, m_cy, m_size;
  assign m_cx   = rdata[47:32];
  assign m_cy   = rdata[31:16];
  assign m_size = rdata[15:0];

  assign in_ready = (state == S_IDLE);

  // Shared multiplier
  logic signed [17:0] mul_a;
  logic signed [35:0] mul_p;
  always_comb begin
    case (state)
      S_SQY:   mul_a = dy_r;
      S_RR:    mul_a = $signed({2'b00, center_radius});
      default: mul_a = dx_r;
    endcase
  end
  assign mul_p = mul_a * mul_a;

  logic [33:0] sq_sum;
  assign sq_sum = acc + 34'(mul_p);

  // Root unit: one bit pair per cycle
  logic [19:0] rem_sh;
  logic [18:0] trial;
  logic        take;
  logic [17:0] rem_next;
  logic [16:0] root_next;
  assign rem_sh    = {rem, rad[33:32]};
  assign trial     = {root, 2'b01};
  assign take      = rem_sh >= 20'(trial);
  assign rem_next  = take ? 18'(rem_sh - 20'(trial)) : rem_sh[17:0];
  assign root_next = take ? {root[15:0], 1'b1} : {root[15:0], 1'b0};
  logic root_done;
  assign root_done = (root_cnt == 5'(ROOT_STEPS - 1));

  // Observation centre and saturated size
  logic [17:0] sum_x, sum_y;
  assign sum_x = 18'(c_q[0]) + 18'(c_q[2]) + 18'(c_q[4]) + 18'(c_q[6]);
  assign sum_y = 18'(c_q[1]) + 18'(c_q[3]) + 18'(c_q[5]) + 18'(c_q[7]);
  logic [15:0] size_sat;
  assign size_sat = root_next[16] ? 16'hFFFF : root_next[15:0];

  // Selection score: 2*root - size
  logic signed [19:0] score;
  assign score = $signed({2'b00, root_next, 1'b0}) - $signed({4'b0000, m_size});

  logic eligible;
  assign eligible = seen_bits[idx] && !scanned_bits[idx];

  logic need_pick;
  assign need_pick = !target_held || scanned_bits[target_reg];

  // Classification of the held target
  logic               centred, moderate, is_lock;
  logic [3:0]         cls_ins;
  logic [11:0]        cls_amt;
  logic [1:0]         cls_mode;
  logic signed [18:0] dx2, r19;
  logic signed [21:0] dx10, r3;
  logic signed [17:0] r18;
  logic [17:0]        ax, ay;
  logic [15:0]        gap;
  logic [29:0]        div5;
  always_comb begin
    centred  = acc < 34'(rr);
    moderate = {acc, 2'b00} < (36'(rr) + {1'b0, rr, 3'b000});
    is_lock  = centred && (m_size > lock_size);
    dx2      = {dx_r, 1'b0};
    r19      = $signed({3'b000, center_radius});
    r18      = $signed({2'b00, center_radius});
    dx10     = (22'(dx_r) <<< 3) + (22'(dx_r) <<< 1);
    r3       = $signed({6'b0, center_radius} + {5'b0, center_radius, 1'b0});
    ax       = dx_r[17] ? 18'(-dx_r) : 18'(dx_r);
    ay       = dy_r[17] ? 18'(-dy_r) : 18'(dy_r);
    gap      = lock_size - m_size;
    div5     = 30'(gap[15:2]) * 30'(RECIP5);
    cls_ins  = INS_FORWARD;
    cls_amt  = '0;
    cls_mode = MODE_TRACKING;
    if (is_lock) begin
      cls_ins  = INS_LOCKED;
      cls_mode = MODE_LOCKED;
    end else if (m_size < far_size) begin
      cls_mode = MODE_APPROACH;
      cls_amt  = AMT_FAR;
      if (!moderate) begin
        if (dx2 > r19) cls_ins = INS_HINT_RIGHT;
        else if (dx2 < -r19) cls_ins = INS_HINT_LEFT;
      end
    end else if (m_size < lock_size) begin
      cls_mode = MODE_APPROACH;
      if (moderate) begin
        cls_amt = div5[29:18];
      end else begin
        cls_ins = (dx_r > 0) ? INS_FWD_TURN_R : INS_FWD_TURN_L;
        cls_amt = 12'(gap >> 5);
      end
    end else if (ax > ay) begin
      if (dx10 > r3) begin
        cls_ins = INS_TURN_RIGHT;
        cls_amt = 12'(ax >> 7);
      end else if (dx10 < -r3) begin
        cls_ins = INS_TURN_LEFT;
        cls_amt = 12'(ax >> 7);
      end else begin
        cls_amt = AMT_CENTRED;
      end
    end else begin
      if (dy_r > r18) cls_ins = INS_CAMERA_DOWN;
      else if (dy_r < -r18) cls_ins = INS_CAMERA_UP;
      else cls_amt = AMT_VERT;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= RST_FRAME_WIDTH;
      frame_height  <= RST_FRAME_HEIGHT;
      center_radius <= RST_CENTER_RADIUS;
      lock_size     <= RST_LOCK_SIZE;
      far_size      <= RST_FAR_SIZE;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_FRAME_WIDTH:   frame_width   <= cfg_wdata[11:0];
        REG_FRAME_HEIGHT:  frame_height  <= cfg_wdata[11:0];
        REG_CENTER_RADIUS: center_radius <= cfg_wdata;
        REG_LOCK_SIZE:     lock_size     <= cfg_wdata;
        REG_FAR_SIZE:      far_size      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Marker store: registered read, single write at end of an observation
  always_comb begin
    rd_addr = (state == S_TRD) ? target_reg : idx;
  end
  always_ff @(posedge clk) begin
    if (state == S_SCAN || state == S_TRD) begin
      rdata <= mem[rd_addr];
    end
    if (state == S_ROOT && root_done && job == JOB_OBS) begin
      mem[ID_W'(id_q)] <= {sum_x[17:2], sum_y[17:2], size_sat};
    end
  end

  // Datapath registers without reset
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        id_q   <= marker_id;
        c_q[0] <= corner0_x;
        c_q[1] <= corner0_y;
        c_q[2] <= corner1_x;
        c_q[3] <= corner1_y;
        c_q[4] <= corner2_x;
        c_q[5] <= corner2_y;
        c_q[6] <= corner3_x;
        c_q[7] <= corner3_y;
        // corner0 to corner2 diagonal
        dx_r <= $signed({2'b00, corner0_x}) - $signed({2'b00, corner2_x});
        dy_r <= $signed({2'b00, corner0_y}) - $signed({2'b00, corner2_y});
      end
      S_FETCH: begin
        // offset from the frame centre (width*8 in Q12.4)
        dx_r <= $signed({2'b00, m_cx}) - $signed({3'b000, frame_width, 3'b000});
        dy_r <= $signed({2'b00, m_cy}) - $signed({3'b000, frame_height, 3'b000});
      end
      S_SQX: acc <= 34'(mul_p);
      S_SQY: begin
        acc  <= sq_sum;
        rad  <= sq_sum;
        rem  <= '0;
        root <= '0;
      end
      S_ROOT: begin
        rem  <= rem_next;
        root <= root_next;
        rad  <= {rad[31:0], 2'b00};
      end
      S_RR: rr <= 32'(mul_p);
      default: ;
    endcase
  end

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      job          <= JOB_OBS;
      seen_bits    <= '0;
      scanned_bits <= '0;
      found_cnt    <= '0;
      scanned_cnt  <= '0;
      target_reg   <= '0;
      target_held  <= 1'b0;
      mode_reg     <= MODE_SCANNING;
      idx          <= '0;
      best_found   <= 1'b0;
      best_id      <= '0;
      best_score   <= '0;
      root_cnt     <= '0;
      res_ins      <= INS_ROTATE_SCAN;
      res_amt      <= '0;
      out_valid    <= 1'b0;
    end else begin
      // drop the result once taken, unless a new one is loaded this cycle
      if (state != S_EMIT && out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (!operation) begin
              job <= JOB_OBS;
              // drop ids outside the store
              if (32'(marker_id) < MARKER_IDS) state <= S_SQX;
            end else if (found_cnt == '0) begin
              mode_reg <= MODE_SCANNING;
              res_ins  <= INS_ROTATE_SCAN;
              res_amt  <= '0;
              state    <= S_EMIT;
            end else if (need_pick) begin
              idx        <= '0;
              best_found <= 1'b0;
              state      <= S_SCAN;
            end else begin
              state <= S_TRD;
            end
          end
        end
        S_SCAN: begin
          if (eligible) begin
            job   <= JOB_SCAN;
            state <= S_FETCH;
          end else if (idx == IDX_LAST) begin
            state <= S_PICK;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_TRD: begin
          job   <= JOB_TGT;
          state <= S_FETCH;
        end
        S_FETCH: state <= S_SQX;
        S_SQX:   state <= S_SQY;
        S_SQY: begin
          root_cnt <= '0;
          state    <= (job == JOB_TGT) ? S_RR : S_ROOT;
        end
        S_ROOT: begin
          root_cnt <= root_cnt + 1'b1;
          if (root_done) begin
            if (job == JOB_OBS) begin
              state <= S_IDLE;
              if (!seen_bits[ID_W'(id_q)]) begin
                seen_bits[ID_W'(id_q)] <= 1'b1;
                if (found_cnt != 7'd127) found_cnt <= found_cnt + 1'b1;
              end
            end else begin
              // lowest score wins, ties keep the lower id
              if (!best_found || score < best_score) begin
                best_found <= 1'b1;
                best_score <= score;
                best_id    <= idx;
              end
              if (idx == IDX_LAST) begin
                state <= S_PICK;
              end else begin
                idx   <= idx + 1'b1;
                state <= S_SCAN;
              end
            end
          end
        end
        S_PICK: begin
          if (!best_found) begin
            target_held <= 1'b0;
            target_reg  <= '0;
            mode_reg    <= MODE_SCANNING;
            res_ins     <= INS_DONE;
            res_amt     <= '0;
            state       <= S_EMIT;
          end else begin
            target_held <= 1'b1;
            target_reg  <= best_id;
            state       <= S_TRD;
          end
        end
        S_RR: state <= S_CLASS;
        S_CLASS: begin
          mode_reg <= cls_mode;
          res_ins  <= cls_ins;
          res_amt  <= cls_amt;
          if (is_lock) begin
            scanned_bits[target_reg] <= 1'b1;
            if (scanned_cnt != 7'd127) scanned_cnt <= scanned_cnt + 1'b1;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (state == S_EMIT && (!out_valid || out_ready)) begin
      instruction   <= res_ins;
      amount        <= res_amt;
      mode          <= mode_reg;
      target_valid  <= target_held;
      target_id     <= target_held ? 6'(target_reg) : 6'd0;
      found_count   <= found_cnt;
      scanned_count <= scanned_cnt;
    end
  end

  // A held target is always a marker that has been observed.
  a_target_seen: assert property (@(posedge clk) disable iff (rst)
    target_held |-> seen_bits[target_reg])
    else $error("held target was never observed");

  // Only observed markers can be marked scanned.
  a_scanned_subset: assert property (@(posedge clk) disable iff (rst)
    (scanned_bits & ~seen_bits) == '0)
    else $error("scanned marker not seen");

  // The scanned counter tracks the scanned flags until it saturates.
  a_scanned_count: assert property (@(posedge clk) disable iff (rst)
    (scanned_cnt == 7'd127) || ($countones(scanned_bits) == 32'(scanned_cnt)))
    else $error("scanned counter out of step");

  // A lock instruction always reports the locked mode.
  a_lock_mode: assert property (@(posedge clk) disable iff (rst)
    (out_valid && instruction == INS_LOCKED) |-> (mode == MODE_LOCKED))
    else $error("lock reported outside locked mode");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for marker_target_steering_core: observations and decide
// transactions are driven, each decision is predicted and compared field by field.
// Depends on mts_pkg and marker_target_steering_core.
module testbench;
  import mts_pkg::*;

  localparam int IDS         = 64;
  localparam int STALL_LIMIT = 20000; // well above one full re-pick plus the long hold-off
  localparam int HOLD_CYCLES = 2000;
  localparam int SETTLE      = 64;    // covers an observation still in flight

  typedef struct packed {
    logic            op;
    logic [5:0]      id;
    logic [7:0][15:0] cn; // c0x, c0y, c1x, c1y, c2x, c2y, c3x, c3y
  } sighting_t;

  typedef struct packed {
    logic [3:0]  instruction;
    logic [11:0] amount;
    logic [1:0]  mode;
    logic        tvalid;
    logic [5:0]  tid;
    logic [6:0]  found;
    logic [6:0]  scanned;
  } steer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  sighting_t cur = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [3:0] instruction;
  logic [11:0] amount;
  logic [1:0] mode;
  logic target_valid;
  logic [5:0] target_id;
  logic [6:0] found_count, scanned_count;

  marker_target_steering_core #(.MARKER_IDS(IDS)) DUT (
    .clk, .rst, .cfg_wr_en, .cfg_addr, .cfg_wdata,
    .in_valid, .in_ready, .operation(cur.op), .marker_id(cur.id),
    .corner0_x(cur.cn[0]), .corner0_y(cur.cn[1]), .corner1_x(cur.cn[2]),
    .corner1_y(cur.cn[3]), .corner2_x(cur.cn[4]), .corner2_y(cur.cn[5]),
    .corner3_x(cur.cn[6]), .corner3_y(cur.cn[7]),
    .out_valid, .out_ready, .instruction, .amount, .mode, .target_valid,
    .target_id, .found_count, .scanned_count
  );

  initial forever #5 clk = ~clk;

  // Predictor state: mirrors the block's marker store, counters and registers.
  bit          seen_id [IDS];
  bit          scanned_id [IDS];
  bit [15:0]   cx_mem [IDS];
  bit [15:0]   cy_mem [IDS];
  bit [15:0]   size_mem [IDS];
  int          found_n, scanned_n;
  bit [5:0]    tgt;
  bit          tgt_held;
  logic [1:0]  mode_q;
  longint      fw, fh, radius, lock_sz, far_sz;

  steer_t pending_steer[$];
  int     errors = 0;
  bit     calm = 1'b0;     // no idling on either side in the last part
  bit     hold_req = 1'b0; // receiver holds off for a long stretch

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic void reset_model();
    fw = RST_FRAME_WIDTH; fh = RST_FRAME_HEIGHT; radius = RST_CENTER_RADIUS;
    lock_sz = RST_LOCK_SIZE; far_sz = RST_FAR_SIZE;
    for (int i = 0; i < IDS; i++) begin
      seen_id[i] = 0; scanned_id[i] = 0;
    end
    found_n = 0; scanned_n = 0; tgt = 0; tgt_held = 0; mode_q = MODE_SCANNING;
  endfunction

  function automatic void store_sighting(sighting_t s);
    longint unsigned sx, sy, d2, sz;
    longint dx, dy;
    sx = longint'(s.cn[0]) + s.cn[2] + s.cn[4] + s.cn[6];
    sy = longint'(s.cn[1]) + s.cn[3] + s.cn[5] + s.cn[7];
    cx_mem[s.id] = 16'(sx >> 2);
    cy_mem[s.id] = 16'(sy >> 2);
    dx = longint'(s.cn[0]) - longint'(s.cn[4]);
    dy = longint'(s.cn[1]) - longint'(s.cn[5]);
    d2 = dx * dx + dy * dy;
    sz = floor_root(d2);
    size_mem[s.id] = (sz > 65535) ? 16'hFFFF : sz[15:0];
    if (!seen_id[s.id]) begin
      seen_id[s.id] = 1;
      if (found_n < 127) found_n++;
    end
  endfunction

  function automatic steer_t pack_steer(logic [3:0] ins, longint unsigned amt);
    steer_t r;
    r.instruction = ins;
    r.amount = (amt > 4095) ? 12'hFFF : amt[11:0];
    r.mode = mode_q;
    r.tvalid = tgt_held;
    r.tid = tgt_held ? tgt : 6'd0;
    r.found = found_n[6:0];
    r.scanned = scanned_n[6:0];
    return r;
  endfunction

  function automatic longint centre_dx(int id);
    return longint'(cx_mem[id]) - fw * 8;
  endfunction

  function automatic longint centre_dy(int id);
    return longint'(cy_mem[id]) - fh * 8;
  endfunction

  function automatic steer_t predict_steering();
    bit any, found;
    longint best, score, dx, dy, ax, ay;
    int best_id;
    longint unsigned d2, rr;
    bit centred, moderate;
    logic [3:0] ins;
    any = 0;
    for (int i = 0; i < IDS; i++) if (seen_id[i]) any = 1;
    if (!any) begin
      mode_q = MODE_SCANNING;
      return pack_steer(INS_ROTATE_SCAN, 0);
    end
    // Re-pick when nothing is held or the held marker got scanned.
    if (!tgt_held || !seen_id[tgt] || scanned_id[tgt]) begin
      found = 0; best = 0; best_id = 0;
      for (int i = 0; i < IDS; i++) begin
        if (!seen_id[i] || scanned_id[i]) continue;
        dx = centre_dx(i); dy = centre_dy(i);
        score = 2 * longint'(floor_root(dx * dx + dy * dy)) - longint'(size_mem[i]);
        if (!found || score < best) begin
          found = 1; best = score; best_id = i;
        end
      end
      if (!found) begin
        tgt_held = 0; tgt = 0; mode_q = MODE_SCANNING;
        return pack_steer(INS_DONE, 0);
      end
      tgt_held = 1; tgt = 6'(best_id);
    end
    dx = centre_dx(tgt); dy = centre_dy(tgt);
    d2 = dx * dx + dy * dy;
    rr = radius * radius;
    centred = d2 < rr;
    moderate = 4 * d2 < 9 * rr;
    if (centred && size_mem[tgt] > lock_sz) begin
      // Lock marks the target scanned immediately.
      mode_q = MODE_LOCKED;
      scanned_id[tgt] = 1;
      if (scanned_n < 127) scanned_n++;
      return pack_steer(INS_LOCKED, 0);
    end
    if (size_mem[tgt] < far_sz) begin
      mode_q = MODE_APPROACH;
      ins = INS_FORWARD;
      if (!moderate) begin
        if (2 * dx > radius) ins = INS_HINT_RIGHT;
        else if (2 * dx < -radius) ins = INS_HINT_LEFT;
      end
      return pack_steer(ins, AMT_FAR);
    end
    if (size_mem[tgt] < lock_sz) begin
      mode_q = MODE_APPROACH;
      if (moderate) return pack_steer(INS_FORWARD, (lock_sz - size_mem[tgt]) / 20);
      return pack_steer(dx > 0 ? INS_FWD_TURN_R : INS_FWD_TURN_L,
                        (lock_sz - size_mem[tgt]) / 32);
    end
    mode_q = MODE_TRACKING;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    if (ax > ay) begin
      if (10 * dx > 3 * radius) return pack_steer(INS_TURN_RIGHT, ax / 128);
      if (10 * dx < -3 * radius) return pack_steer(INS_TURN_LEFT, ax / 128);
      return pack_steer(INS_FORWARD, AMT_CENTRED);
    end
    if (dy > radius) return pack_steer(INS_CAMERA_DOWN, 0);
    if (dy < -radius) return pack_steer(INS_CAMERA_UP, 0);
    return pack_steer(INS_FORWARD, AMT_VERT);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  // Compare every accepted decision against the oldest prediction.
  always @(posedge clk) begin
    steer_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_steer.size() == 0) report_mismatch("unexpected result", instruction, -1);
      else begin
        want = pending_steer[0];
        pending_steer.delete(0);
        if (instruction !== want.instruction)
          report_mismatch("instruction", instruction, want.instruction);
        if (amount !== want.amount) report_mismatch("amount", amount, want.amount);
        if (mode !== want.mode) report_mismatch("mode", mode, want.mode);
        if (target_valid !== want.tvalid)
          report_mismatch("target_valid", target_valid, want.tvalid);
        if (target_id !== want.tid) report_mismatch("target_id", target_id, want.tid);
        if (found_count !== want.found)
          report_mismatch("found_count", found_count, want.found);
        if (scanned_count !== want.scanned)
          report_mismatch("scanned_count", scanned_count, want.scanned);
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else if (quiet_cycles >= STALL_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end else quiet_cycles <= quiet_cycles + 1;
  end

  // Receiver: random stall bursts, a long hold-off on request, none when calm.
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 7);
        out_ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else out_ready <= 1'b1;
    end
  end

  // Offer one transaction; returns right after the accepting edge with valid still up.
  task automatic send_item(sighting_t s);
    int n;
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    cur <= s;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (s.op) pending_steer = {pending_steer, predict_steering()};
    else store_sighting(s);
  endtask

  task automatic input_idle();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Drain all decisions, then let a trailing observation finish.
  task automatic settle();
    input_idle();
    while (pending_steer.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, longint val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val[15:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:   fw = val & 12'hFFF;
      REG_FRAME_HEIGHT:  fh = val & 12'hFFF;
      REG_CENTER_RADIUS: radius = val & 16'hFFFF;
      REG_LOCK_SIZE:     lock_sz = val & 16'hFFFF;
      REG_FAR_SIZE:      far_sz = val & 16'hFFFF;
      default: ;
    endcase
  endtask

  task automatic set_config(longint w, longint h, longint r, longint lk, longint fr);
    settle();
    cfg_write(REG_FRAME_WIDTH, w);
    cfg_write(REG_FRAME_HEIGHT, h);
    cfg_write(REG_CENTER_RADIUS, r);
    cfg_write(REG_LOCK_SIZE, lk);
    cfg_write(REG_FAR_SIZE, fr);
  endtask

  function automatic logic [15:0] clamp16(longint v);
    return v < 0 ? 16'd0 : (v > 65535 ? 16'hFFFF : v[15:0]);
  endfunction

  // Square marker around (x, y) with half side hs.
  function automatic sighting_t square_at(int id, longint x, longint y, longint hs);
    sighting_t s;
    s.op = 1'b0;
    s.id = 6'(id);
    s.cn[0] = clamp16(x - hs); s.cn[1] = clamp16(y - hs);
    s.cn[2] = clamp16(x + hs); s.cn[3] = clamp16(y - hs);
    s.cn[4] = clamp16(x + hs); s.cn[5] = clamp16(y + hs);
    s.cn[6] = clamp16(x - hs); s.cn[7] = clamp16(y + hs);
    return s;
  endfunction

  function automatic sighting_t decide_item();
    sighting_t s;
    s = '0;
    s.op = 1'b1;
    s.id = 6'($urandom);       // ignored fields still toggle
    for (int i = 0; i < 8; i++) s.cn[i] = 16'($urandom);
    return s;
  endfunction

  function automatic sighting_t noise_item();
    sighting_t s;
    s.op = 1'b0;
    s.id = 6'($urandom);
    for (int i = 0; i < 8; i++) s.cn[i] = 16'($urandom);
    return s;
  endfunction

  task automatic test_directed_cases();
    sighting_t s;
    longint x0, y0;
    x0 = fw * 8; y0 = fh * 8;
    send_item(decide_item());                     // nothing seen yet
    send_item(square_at(5, x0, y0, 1000));         // big and centred: lock
    send_item(decide_item());
    send_item(decide_item());                      // nothing unscanned left: done
    send_item(square_at(63, x0 + 3000, y0, 100));  // far, off right: hint right
    send_item(decide_item());
    send_item(square_at(63, x0 - 3000, y0, 100));  // far, off left: hint left
    send_item(decide_item());
    send_item(square_at(63, x0, y0, 500));         // medium, centred: forward
    send_item(decide_item());
    send_item(square_at(63, x0 + 3000, y0, 500));  // medium, off: forward and turn
    send_item(decide_item());
    send_item(square_at(63, x0 - 3000, y0, 500));
    send_item(decide_item());
    send_item(square_at(63, x0 + 2500, y0, 1000)); // near, horizontal turns
    send_item(decide_item());
    send_item(square_at(63, x0 - 2500, y0, 1000));
    send_item(decide_item());
    send_item(square_at(63, x0 + 500, y0 + 2000, 1000)); // near, vertical camera
    send_item(decide_item());
    send_item(square_at(63, x0 + 500, y0 - 2000, 1000));
    send_item(decide_item());
    s = square_at(0, 0, 0, 0);                     // corner extremes, saturated size
    send_item(s);
    s.id = 1;
    for (int i = 0; i < 8; i++) s.cn[i] = 16'hFFFF;
    send_item(s);
    s.id = 2; s.cn[0] = 0; s.cn[1] = 0;
    send_item(s);
    send_item(decide_item());
  endtask

  // Mostly well-formed squares near the frame centre, some noise, ~30% decides.
  task automatic test_random_traffic(int count);
    longint x0, y0, spread, hs;
    int id;
    for (int k = 0; k < count; k++) begin
      x0 = fw * 8; y0 = fh * 8;
      spread = (radius > 200 ? radius : 200) * 2;
      if (spread > 30000) spread = 30000;
      id = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 7) : $urandom_range(0, IDS - 1);
      hs = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40000) : $urandom_range(0, 1500);
      case ($urandom_range(0, 9))
        0, 1, 2: send_item(decide_item());
        3:       send_item(noise_item());
        default: send_item(square_at(id,
                   x0 + longint'($urandom_range(0, 2 * spread)) - spread,
                   y0 + longint'($urandom_range(0, 2 * spread)) - spread, hs));
      endcase
    end
  endtask

  task automatic test_extreme_config();
    set_config(1, 1, 0, 0, 0);
    test_random_traffic(70);
    set_config(4095, 4095, 65535, 65535, 65535);
    test_random_traffic(70);
    set_config($urandom_range(1, 4095), $urandom_range(1, 4095), $urandom_range(0, 4000),
               $urandom_range(0, 4000), $urandom_range(0, 2000));
    test_random_traffic(90);
    set_config(RST_FRAME_WIDTH, RST_FRAME_HEIGHT, RST_CENTER_RADIUS, RST_LOCK_SIZE,
               RST_FAR_SIZE);
  endtask

  // Hold the receiver off while decides keep coming, then pause until drained.
  task automatic test_output_stall();
    send_item(square_at(9, fw * 8 + 3000, fh * 8, 100));
    hold_req = 1'b1;
    repeat (8) send_item(decide_item());
    input_idle();
    while (pending_steer.size() != 0) @(posedge clk);
  endtask

  task automatic test_steady_stream();
    calm = 1'b1;
    test_random_traffic(100);
  endtask

  initial begin
    reset_model();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_random_traffic(130);
    test_extreme_config();
    test_output_stall();
    test_steady_stream();
    settle();
    repeat (100) @(posedge clk);
    if (errors == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/mts_pkg.sv
hw/rtl/marker_target_steering_core.sv
tb/testbench.sv
